/* sv/ghbdc_pkg.sv */
// ----------------------------------------------------------------------------
// ghbdc_pkg
// Shared types and constants of the delta-correlation prefetcher core.
// ----------------------------------------------------------------------------
package ghbdc_pkg;

  localparam int ADDR_W      = 48;
  localparam int PC_W        = 48;
  localparam int LINE_W      = 42;
  localparam int TAG_W       = 40;
  localparam int STAMP_W     = 32;
  localparam int DELTA_W     = 8;
  localparam int CFG_W       = 5;
  localparam int DELTA_LIMIT = 100;

  // register map
  localparam logic REG_DEGREE = 1'b0;
  localparam logic [CFG_W-1:0] DEGREE_RESET = 5'd4;

  // one cache access
  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic              was_hit;
    logic [PC_W-1:0]   load_pc;
  } access_t;

  // one prefetch request
  typedef struct packed {
    logic [LINE_W-1:0] prefetch_line;
    logic [PC_W-1:0]   request_pc;
    logic              last_of_run;
  } prefetch_t;

  // classified access, queued between front and back
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [TAG_W-1:0]  tag;
    logic              was_hit;
    logic [PC_W-1:0]   pc;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REPCHK,
    S_APP0,
    S_APP1,
    S_APP2,
    S_APP3,
    S_WRD,
    S_WEV,
    S_STRIDE,
    S_RRD,
    S_REMIT
  } back_state_t;

endpackage

/* sv/ghb_delta_correlation_prefetcher_core.sv */
// ----------------------------------------------------------------------------
// ghb_delta_correlation_prefetcher_core
// Global history buffer delta-correlation prefetcher with APB degree register.
// ----------------------------------------------------------------------------
// Each access is taken from the queue, then the zone table is swept
// (one entry a cycle through the table's single read port), the history entry
// is checked and appended, and the chain is walked one history entry at a time
// (one registered history read each); stride prefetches or replayed prefetches
// are then issued, subject to any output stall. A two-entry queue takes new
// accesses while the engine works, and the output register holds one request.
module ghb_delta_correlation_prefetcher_core
  import ghbdc_pkg::*;
#(
  parameter int ZONE_ENTRIES    = 64,
  parameter int HISTORY_ENTRIES = 256,
  parameter int MAX_DEGREE      = 16,
  parameter int LINE_SHIFT      = 6,
  parameter int ZONE_SHIFT      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  access_t     acc_data,
  input  logic        acc_valid,
  output logic        acc_ready,
  output prefetch_t   pf_data,
  output logic        pf_valid,
  input  logic        pf_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] degree;
  job_t             job;
  logic             job_valid;
  logic             job_ready;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEGREE) ? {{(32-CFG_W){1'b0}}, degree} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEGREE) begin
      degree <= pwdata[CFG_W-1:0];
    end
  end

  ghbdc_front #(
    .LINE_SHIFT (LINE_SHIFT),
    .ZONE_SHIFT (ZONE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .acc_data  (acc_data),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  ghbdc_back #(
    .ZONE_ENTRIES    (ZONE_ENTRIES),
    .HISTORY_ENTRIES (HISTORY_ENTRIES),
    .MAX_DEGREE      (MAX_DEGREE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .degree    (degree),
    .pf_data   (pf_data),
    .pf_valid  (pf_valid),
    .pf_ready  (pf_ready)
  );

endmodule

/* sv/ghbdc_front.sv */
// ----------------------------------------------------------------------------
// ghbdc_front
// Accepts accesses, splits out line index and zone tag, and queues them.
// ----------------------------------------------------------------------------
module ghbdc_front
  import ghbdc_pkg::*;
#(
  parameter int LINE_SHIFT = 6,
  parameter int ZONE_SHIFT = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  access_t acc_data,
  input  logic    acc_valid,
  output logic    acc_ready,
  output job_t    job,
  output logic    job_valid,
  input  logic    job_ready
);

  job_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic [ADDR_W-1:0] line_sh;
  logic [ADDR_W-1:0] zone_sh;
  job_t       job_in;

  // classify the incoming access
  assign line_sh = acc_data.byte_address >> LINE_SHIFT;
  assign zone_sh = acc_data.byte_address >> ZONE_SHIFT;
  always_comb begin
    job_in.line    = line_sh[LINE_W-1:0];
    job_in.tag     = zone_sh[TAG_W-1:0];
    job_in.was_hit = acc_data.was_hit;
    job_in.pc      = acc_data.load_pc;
  end

  assign acc_ready = (cnt != 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rptr];
  assign push      = acc_valid && acc_ready;
  assign pop       = job_valid && job_ready;

  // two-entry queue: advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold queued payload
  always_ff @(posedge clk) begin
    if (push) q[wptr] <= job_in;
  end

endmodule

/* sv/ghbdc_back.sv */
// ----------------------------------------------------------------------------
// ghbdc_back
// Zone lookup, history append, chain walk and prefetch issue sequencer.
// ----------------------------------------------------------------------------
module ghbdc_back
  import ghbdc_pkg::*;
#(
  parameter int ZONE_ENTRIES    = 64,
  parameter int HISTORY_ENTRIES = 256,
  parameter int MAX_DEGREE      = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  job_t             job,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [CFG_W-1:0] degree,
  output prefetch_t        pf_data,
  output logic             pf_valid,
  input  logic             pf_ready
);

  localparam int ZI = $clog2(ZONE_ENTRIES);
  localparam int ZW = $clog2(ZONE_ENTRIES + 1);
  localparam int HI = $clog2(HISTORY_ENTRIES);
  localparam int HW = $clog2(HISTORY_ENTRIES + 1);
  localparam int RS = MAX_DEGREE + 2;
  localparam int RI = $clog2(RS);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int CW = $clog2(HISTORY_ENTRIES + 1);
  localparam int ZMW = TAG_W + HI + STAMP_W;
  localparam logic [HW-1:0] HNULL = HW'(HISTORY_ENTRIES);
  localparam logic [ZW-1:0] ZNULL = ZW'(ZONE_ENTRIES);

  // memories
  logic [ZMW-1:0]    zmem  [ZONE_ENTRIES];
  logic [LINE_W-1:0] hline [HISTORY_ENTRIES];
  logic [HW-1:0]     hprev [HISTORY_ENTRIES];
  logic [HW-1:0]     hnext [HISTORY_ENTRIES];
  logic [ZW-1:0]     hown  [HISTORY_ENTRIES];
  logic [DELTA_W-1:0] rmem [RS];

  logic              zm_we;
  logic [ZI-1:0]     zm_waddr;
  logic [ZMW-1:0]    zm_wdata;
  logic [ZI-1:0]     zm_raddr;
  logic [ZMW-1:0]    zm_rdata;
  logic [HI-1:0]     h_raddr;
  logic              hl_we;
  logic [HI-1:0]     hl_waddr;
  logic [LINE_W-1:0] hl_wdata;
  logic [LINE_W-1:0] hl_rdata;
  logic              hp_we;
  logic [HI-1:0]     hp_waddr;
  logic [HW-1:0]     hp_wdata;
  logic [HW-1:0]     hp_rdata;
  logic              hn_we;
  logic [HI-1:0]     hn_waddr;
  logic [HW-1:0]     hn_wdata;
  logic [HW-1:0]     hn_rdata;
  logic              ho_we;
  logic [HI-1:0]     ho_waddr;
  logic [ZW-1:0]     ho_wdata;
  logic [ZW-1:0]     ho_rdata;
  logic              rg_we;
  logic [RI-1:0]     rg_waddr;
  logic [DELTA_W-1:0] rg_wdata;
  logic [DELTA_W-1:0] rg_rdata;
  logic              rg_rvalid;

  // control and working registers
  back_state_t state, state_next;
  job_t        jq, jq_next;
  logic [ZONE_ENTRIES-1:0] zvalid, zvalid_next;
  logic [RS-1:0]     rvalid, rvalid_next;
  logic [HW-1:0]     tail, tail_next;
  logic              wrapped, wrapped_next;
  logic [STAMP_W-1:0] use_stamp, use_stamp_next;
  logic [ZW-1:0]     scan_idx, scan_idx_next;
  logic              scan_pend, scan_pend_next;
  logic [ZI-1:0]     scan_didx, scan_didx_next;
  logic              found, found_next;
  logic [ZI-1:0]     mzi, mzi_next;
  logic [HI-1:0]     mold, mold_next;
  logic              inv_found, inv_found_next;
  logic [ZI-1:0]     invi, invi_next;
  logic              min_found, min_found_next;
  logic [STAMP_W-1:0] min_stamp, min_stamp_next;
  logic [ZI-1:0]     mini, mini_next;
  logic [ZI-1:0]     zi, zi_next;
  logic [HW-1:0]     old, old_next;
  logic [HI-1:0]     t, t_next;
  logic              tvalid, tvalid_next;
  logic              own_chk, own_chk_next;
  logic [ZI-1:0]     own, own_next;
  logic [DW-1:0]     deg, deg_next;
  logic [HW-1:0]     g, g_next;
  logic [LINE_W-1:0] cur, cur_next;
  logic [LINE_W-1:0] base, base_next;
  logic [RI-1:0]     hpos, hpos_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     steps, steps_next;
  logic signed [DELTA_W-1:0] d1, d1_next;
  logic signed [DELTA_W-1:0] d2, d2_next;
  logic signed [DELTA_W-1:0] prev_d, prev_d_next;
  logic [DW-1:0]     sent, sent_next;
  logic [RI-1:0]     r, r_next;
  logic [RI-1:0]     start, start_next;
  logic              pf_valid_next;
  prefetch_t         pf_next;

  // combinational helpers
  logic              pf_free;
  logic [TAG_W-1:0]  zr_tag;
  logic [HI-1:0]     zr_head;
  logic [STAMP_W-1:0] zr_stamp;
  logic [HI-1:0]     t_c;
  logic [LINE_W-1:0] diff_up;
  logic [LINE_W-1:0] diff_dn;
  logic              far;
  logic signed [DELTA_W-1:0] d;
  logic [RI-1:0]     hpos_c;
  logic [RI-1:0]     r_c;
  logic [31:0]       degw;
  logic              last;
  logic [DELTA_W-1:0] ring_val;
  logic [HW-1:0]     nxt_c;
  logic [ZW-1:0]     own_c;

  assign zr_tag   = zm_rdata[ZMW-1 -: TAG_W];
  assign zr_head  = zm_rdata[STAMP_W +: HI];
  assign zr_stamp = zm_rdata[STAMP_W-1:0];
  assign pf_free  = !pf_valid || pf_ready;
  assign ring_val = rg_rvalid ? rg_rdata : '0;
  assign last     = (32'(sent) + 32'd1 == 32'(deg));
  assign degw     = (32'(degree) > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : 32'(degree);
  assign diff_up  = cur - hl_rdata;
  assign diff_dn  = hl_rdata - cur;
  assign hpos_c   = (hpos == RI'(RS - 1)) ? '0 : hpos + 1'b1;
  assign r_c      = (hpos_c >= RI'(2)) ? hpos_c - RI'(2) : hpos_c + RI'(RS - 2);

  // line delta to the older entry, limited to the near range
  always_comb begin
    if (cur >= hl_rdata) begin
      far = (diff_up > LINE_W'(DELTA_LIMIT));
      d   = DELTA_W'(diff_up);
    end else begin
      far = (diff_dn > LINE_W'(DELTA_LIMIT));
      d   = -DELTA_W'(diff_dn);
    end
  end

  // next ring slot of the wrapping history tail
  always_comb begin
    if (tail == HNULL || tail == HW'(HISTORY_ENTRIES - 1)) t_c = '0;
    else t_c = HI'(tail + 1'b1);
  end

  assign nxt_c = tvalid ? hn_rdata : HNULL;
  assign own_c = tvalid ? ho_rdata : ZNULL;

  // sequencer: next state, memory controls and register updates
  always_comb begin
    state_next     = state;
    jq_next        = jq;
    zvalid_next    = zvalid;
    rvalid_next    = rvalid;
    tail_next      = tail;
    wrapped_next   = wrapped;
    use_stamp_next = use_stamp;
    scan_idx_next  = scan_idx;
    scan_pend_next = scan_pend;
    scan_didx_next = scan_didx;
    found_next     = found;
    mzi_next       = mzi;
    mold_next      = mold;
    inv_found_next = inv_found;
    invi_next      = invi;
    min_found_next = min_found;
    min_stamp_next = min_stamp;
    mini_next      = mini;
    zi_next        = zi;
    old_next       = old;
    t_next         = t;
    tvalid_next    = tvalid;
    own_chk_next   = own_chk;
    own_next       = own;
    deg_next       = deg;
    g_next         = g;
    cur_next       = cur;
    base_next      = base;
    hpos_next      = hpos;
    count_next     = count;
    steps_next     = steps;
    d1_next        = d1;
    d2_next        = d2;
    prev_d_next    = prev_d;
    sent_next      = sent;
    r_next         = r;
    start_next     = start;
    pf_valid_next  = pf_valid && !pf_ready;
    pf_next        = pf_data;
    job_ready      = 1'b0;
    zm_we    = 1'b0;
    zm_waddr = zi;
    zm_wdata = {jq.tag, t_c, use_stamp};
    zm_raddr = scan_idx[ZI-1:0];
    h_raddr  = g[HI-1:0];
    hl_we    = 1'b0;
    hl_waddr = t;
    hl_wdata = jq.line;
    hp_we    = 1'b0;
    hp_waddr = t;
    hp_wdata = old;
    hn_we    = 1'b0;
    hn_waddr = t;
    hn_wdata = HNULL;
    ho_we    = 1'b0;
    ho_waddr = t;
    ho_wdata = ZW'(zi);
    rg_we    = 1'b0;
    rg_waddr = hpos_c;
    rg_wdata = d;

    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_ready      = 1'b1;
          jq_next        = job;
          use_stamp_next = use_stamp + 1'b1;
          scan_idx_next  = '0;
          scan_pend_next = 1'b0;
          found_next     = 1'b0;
          inv_found_next = 1'b0;
          min_found_next = 1'b0;
          state_next     = S_SCAN;
        end
      end

      // sweep the zone table, one entry a cycle
      S_SCAN: begin
        if (scan_idx != ZW'(ZONE_ENTRIES)) begin
          scan_didx_next = scan_idx[ZI-1:0];
          scan_pend_next = 1'b1;
          scan_idx_next  = scan_idx + 1'b1;
        end else begin
          scan_pend_next = 1'b0;
        end
        if (scan_pend) begin
          if (zvalid[scan_didx]) begin
            if (zr_tag == jq.tag) begin
              found_next = 1'b1;
              mzi_next   = scan_didx;
              mold_next  = zr_head;
            end else if (!min_found || zr_stamp < min_stamp) begin
              min_found_next = 1'b1;
              min_stamp_next = zr_stamp;
              mini_next      = scan_didx;
            end
          end else if (!inv_found) begin
            inv_found_next = 1'b1;
            invi_next      = scan_didx;
          end
          if (scan_didx == ZI'(ZONE_ENTRIES - 1)) state_next = S_DECIDE;
        end
      end

      // pick the zone (or drop a hit in an unknown zone) and fetch its newest line
      S_DECIDE: begin
        h_raddr = mold;
        if (found) begin
          zi_next    = mzi;
          old_next   = HW'(mold);
          state_next = S_REPCHK;
        end else if (jq.was_hit) begin
          state_next = S_IDLE;
        end else begin
          zi_next    = inv_found ? invi : mini;
          old_next   = HNULL;
          state_next = S_REPCHK;
        end
      end

      // drop a repeat of the zone's newest line
      S_REPCHK: begin
        if (found && hl_rdata == jq.line) state_next = S_IDLE;
        else state_next = S_APP0;
      end

      // claim the next history slot, update the zone entry
      S_APP0: begin
        h_raddr      = t_c;
        zm_we        = 1'b1;
        zvalid_next[zi] = 1'b1;
        t_next       = t_c;
        tail_next    = HW'(t_c);
        wrapped_next = wrapped || (tail != HNULL && t_c == '0);
        tvalid_next  = wrapped || (tail != HNULL && t_c == '0);
        if (old == HW'(t_c)) old_next = HNULL;
        state_next   = S_APP1;
      end

      // unlink the overwritten slot's newer neighbor
      S_APP1: begin
        if (nxt_c != HNULL) begin
          hp_we    = 1'b1;
          hp_waddr = nxt_c[HI-1:0];
          hp_wdata = HNULL;
        end
        own_chk_next = (own_c != ZNULL) && (own_c[ZI-1:0] != zi);
        own_next     = own_c[ZI-1:0];
        zm_raddr     = own_c[ZI-1:0];
        state_next   = S_APP2;
      end

      // drop a zone whose head was overwritten, store the new entry
      S_APP2: begin
        if (own_chk && zr_head == t) zvalid_next[own] = 1'b0;
        hp_we = 1'b1;
        hl_we = 1'b1;
        hn_we = 1'b1;
        ho_we = 1'b1;
        state_next = S_APP3;
      end

      // link the previous head forward, start the walk
      S_APP3: begin
        if (old != HNULL) begin
          hn_we    = 1'b1;
          hn_waddr = old[HI-1:0];
          hn_wdata = HW'(t);
        end
        deg_next    = degw[DW-1:0];
        g_next      = old;
        cur_next    = jq.line;
        base_next   = jq.line;
        hpos_next   = RI'(RS - 1);
        count_next  = '0;
        steps_next  = '0;
        d1_next     = '0;
        d2_next     = '0;
        sent_next   = '0;
        rvalid_next = '0;
        state_next  = (degw == 32'd0) ? S_IDLE : S_WRD;
      end

      // fetch the next older entry of the chain
      S_WRD: begin
        if (g == HNULL || steps == CW'(HISTORY_ENTRIES)) begin
          state_next = S_IDLE;
        end else begin
          steps_next = steps + 1'b1;
          state_next = S_WEV;
        end
      end

      // record the delta and look for a stride or a repeated pair
      S_WEV: begin
        if (far) begin
          state_next = S_IDLE;
        end else begin
          rg_we       = 1'b1;
          rvalid_next[hpos_c] = 1'b1;
          hpos_next   = hpos_c;
          count_next  = count + 1'b1;
          prev_d_next = d;
          cur_next    = hl_rdata;
          g_next      = hp_rdata;
          state_next  = S_WRD;
          if (d1 == '0) begin
            d1_next = d;
          end else if (d2 == '0) begin
            d2_next = d;
          end else if (d1 == d2) begin
            state_next = S_STRIDE;
          end else if (prev_d == d1 && d == d2) begin
            r_next     = r_c;
            start_next = r_c;
            state_next = S_RRD;
          end
        end
      end

      // issue the stride run
      S_STRIDE: begin
        if (pf_free) begin
          base_next     = base + {{(LINE_W-DELTA_W){d1[DELTA_W-1]}}, d1};
          pf_valid_next = 1'b1;
          pf_next.prefetch_line = base_next;
          pf_next.request_pc    = jq.pc;
          pf_next.last_of_run   = last;
          sent_next     = sent + 1'b1;
          if (last) state_next = S_IDLE;
        end
      end

      S_RRD: begin
        state_next = S_REMIT;
      end

      // replay the deltas that followed the earlier pair
      S_REMIT: begin
        if (pf_free) begin
          base_next     = base + {{(LINE_W-DELTA_W){ring_val[DELTA_W-1]}}, ring_val};
          pf_valid_next = 1'b1;
          pf_next.prefetch_line = base_next;
          pf_next.request_pc    = jq.pc;
          pf_next.last_of_run   = last;
          sent_next     = sent + 1'b1;
          if (last) begin
            state_next = S_IDLE;
          end else begin
            r_next = (r == '0) ? RI'(RS - 1) : r - 1'b1;
            if (32'(r_next) > 32'(count)) r_next = start;
            state_next = S_RRD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      zvalid    <= '0;
      tail      <= HNULL;
      wrapped   <= 1'b0;
      use_stamp <= '0;
      pf_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      zvalid    <= zvalid_next;
      tail      <= tail_next;
      wrapped   <= wrapped_next;
      use_stamp <= use_stamp_next;
      pf_valid  <= pf_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    jq        <= jq_next;
    rvalid    <= rvalid_next;
    scan_idx  <= scan_idx_next;
    scan_pend <= scan_pend_next;
    scan_didx <= scan_didx_next;
    found     <= found_next;
    mzi       <= mzi_next;
    mold      <= mold_next;
    inv_found <= inv_found_next;
    invi      <= invi_next;
    min_found <= min_found_next;
    min_stamp <= min_stamp_next;
    mini      <= mini_next;
    zi        <= zi_next;
    old       <= old_next;
    t         <= t_next;
    tvalid    <= tvalid_next;
    own_chk   <= own_chk_next;
    own       <= own_next;
    deg       <= deg_next;
    g         <= g_next;
    cur       <= cur_next;
    base      <= base_next;
    hpos      <= hpos_next;
    count     <= count_next;
    steps     <= steps_next;
    d1        <= d1_next;
    d2        <= d2_next;
    prev_d    <= prev_d_next;
    sent      <= sent_next;
    r         <= r_next;
    start     <= start_next;
    pf_data   <= pf_next;
  end

  // zone table
  always_ff @(posedge clk) begin
    if (zm_we) zmem[zm_waddr] <= zm_wdata;
    zm_rdata <= zmem[zm_raddr];
  end

  // history buffer fields
  always_ff @(posedge clk) begin
    if (hl_we) hline[hl_waddr] <= hl_wdata;
    hl_rdata <= hline[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (hp_we) hprev[hp_waddr] <= hp_wdata;
    hp_rdata <= hprev[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (hn_we) hnext[hn_waddr] <= hn_wdata;
    hn_rdata <= hnext[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (ho_we) hown[ho_waddr] <= ho_wdata;
    ho_rdata <= hown[h_raddr];
  end

  // delta ring
  always_ff @(posedge clk) begin
    if (rg_we) rmem[rg_waddr] <= rg_wdata;
    rg_rdata  <= rmem[r];
    rg_rvalid <= rvalid[r];
  end

endmodule
